// ===== rtl/slcs_pkg.sv =====
package slcs_pkg;

	// Buffer geometry.
	localparam int BUFFER_DEPTH = 32;
	localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// Saturation limit of the walk counter.
	localparam logic [30:0] WALK_MAX = 31'h7FFF_FFFF;

	// Result status codes.
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_ENDED = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_TRACK_TTF  = 1'b0;
	localparam logic CFG_TRACK_BMAX = 1'b1;

	// One buffered skip entry as held in the entry memory.
	typedef struct packed {
		logic [31:0] doc_delta;
		logic [31:0] offset_delta;
		logic [31:0] ttf_delta;
		logic [31:0] block_max;
		logic [15:0] block_percent;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/slcs_ram.sv =====
module slcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/skip_list_cursor_seek_top.sv =====
// Forward-only cursor over a delta-coded skip list. An append (req_type 0)
// is taken while idle, leaves the block idle and gives no result. A seek
// (req_type 1) walks the buffered entries from the cursor, one entry per
// cycle through the walk adders and a single compare, so busy stays high
// in S_WALK up to and including the hit entry, and when the buffer runs out
// through S_WALK and then S_FIN (only S_FIN when there is nothing left to
// walk). The result is shown for exactly one cycle, marked by done, in the
// first cycle in which busy is low again; the receiver must take it then,
// as it cannot stall the block. The entry memory registers its read data,
// and the next address is issued while the current entry is evaluated.
module skip_list_cursor_seek_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic        first_in_buffer,
	input  logic        final_buffer,
	input  logic [31:0] doc_delta,
	input  logic [31:0] offset_delta,
	input  logic [31:0] ttf_delta,
	input  logic [31:0] block_max_freq,
	input  logic [15:0] block_max_percent,
	input  logic [31:0] seek_doc_id,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data,

	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] found_doc_id,
	output logic [31:0] previous_doc_id,
	output logic [31:0] previous_offset,
	output logic [31:0] hit_offset_delta,
	output logic [31:0] total_term_freq,
	output logic [31:0] current_block_max,
	output logic [15:0] current_block_percent,
	output logic [30:0] skipped_count,
	output logic [31:0] buffer_end_doc,
	output logic [31:0] buffer_end_offset
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FIN
	} state_t;

	state_t                            state_q;
	logic                              track_ttf_q;
	logic                              track_bmax_q;
	logic [slcs_pkg::CNT_W-1:0]        cursor_q;
	logic [slcs_pkg::CNT_W-1:0]        fill_q;
	logic                              final_q;
	logic [31:0]                       run_doc_q;
	logic [31:0]                       run_off_q;
	logic [31:0]                       run_ttf_q;
	logic [31:0]                       prev_doc_q;
	logic [31:0]                       prev_off_q;
	logic [31:0]                       bmax_q;
	logic [15:0]                       bpct_q;
	logic [30:0]                       walk_q;
	logic [31:0]                       end_doc_q;
	logic [31:0]                       end_off_q;
	logic [31:0]                       query_q;
	logic                              done_q;
	logic [1:0]                        status_q;
	logic [31:0]                       hit_delta_q;

	logic                              accept;
	logic                              do_append;
	logic                              do_seek;
	logic [slcs_pkg::CNT_W-1:0]        fill_base;
	logic                              room;
	logic [31:0]                       end_doc_base;
	logic [31:0]                       end_off_base;
	logic [slcs_pkg::CNT_W-1:0]        cursor_nx;
	logic [30:0]                       walk_inc;
	logic [31:0]                       doc_sum;
	logic [31:0]                       off_sum;
	logic [31:0]                       ttf_sum;
	logic                              reached;
	logic                              ram_we;
	logic [slcs_pkg::IDX_W-1:0]        ram_waddr;
	logic [slcs_pkg::IDX_W-1:0]        ram_raddr;
	slcs_pkg::entry_t                  wr_entry;
	slcs_pkg::entry_t                  rd_entry;
	logic [slcs_pkg::ENTRY_W-1:0]      rd_bits;

	// Handshake decode.
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign do_append = accept && !req_type;
	assign do_seek   = accept && req_type;
	assign cfg_ready = 1'b1;

	// Append path: a new buffer restarts the fill and the buffer-end sums.
	assign fill_base    = first_in_buffer ? '0 : fill_q;
	assign room         = (fill_base < slcs_pkg::CNT_W'(slcs_pkg::BUFFER_DEPTH));
	assign end_doc_base = first_in_buffer ? run_doc_q : end_doc_q;
	assign end_off_base = first_in_buffer ? run_off_q : end_off_q;

	assign wr_entry.doc_delta     = doc_delta;
	assign wr_entry.offset_delta  = offset_delta;
	assign wr_entry.ttf_delta     = ttf_delta;
	assign wr_entry.block_max     = block_max_freq;
	assign wr_entry.block_percent = block_max_percent;

	assign ram_we    = do_append && room;
	assign ram_waddr = fill_base[slcs_pkg::IDX_W-1:0];

	// Walk path: the walk adders and the compare work on the entry just read.
	assign cursor_nx = cursor_q + 1'b1;
	assign ram_raddr = (state_q == S_WALK) ? cursor_nx[slcs_pkg::IDX_W-1:0]
	                                       : cursor_q[slcs_pkg::IDX_W-1:0];
	assign rd_entry  = slcs_pkg::entry_t'(rd_bits);
	assign doc_sum   = run_doc_q + rd_entry.doc_delta;
	assign off_sum   = run_off_q + rd_entry.offset_delta;
	assign ttf_sum   = run_ttf_q + rd_entry.ttf_delta;
	assign reached   = (doc_sum >= query_q);
	assign walk_inc  = (walk_q == slcs_pkg::WALK_MAX) ? walk_q : walk_q + 1'b1;

	slcs_ram #(
		.WIDTH(slcs_pkg::ENTRY_W),
		.DEPTH(slcs_pkg::BUFFER_DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.raddr(ram_raddr),
		.rdata(rd_bits)
	);

	// Sequencer, cursor state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			track_ttf_q  <= 1'b0;
			track_bmax_q <= 1'b0;
			cursor_q     <= '0;
			fill_q       <= '0;
			final_q      <= 1'b0;
			run_doc_q    <= '0;
			run_off_q    <= '0;
			run_ttf_q    <= '0;
			prev_doc_q   <= '0;
			prev_off_q   <= '0;
			bmax_q       <= '0;
			bpct_q       <= '0;
			walk_q       <= '0;
			end_doc_q    <= '0;
			end_off_q    <= '0;
			query_q      <= '0;
			done_q       <= 1'b0;
			status_q     <= slcs_pkg::ST_FOUND;
			hit_delta_q  <= '0;
		end else begin
			done_q <= 1'b0;

			// Configuration beats.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					slcs_pkg::CFG_TRACK_TTF:  track_ttf_q  <= cfg_data;
					slcs_pkg::CFG_TRACK_BMAX: track_bmax_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (do_append) begin
						final_q <= final_buffer;
						if (first_in_buffer) begin
							cursor_q <= '0;
						end
						if (room) begin
							fill_q    <= fill_base + 1'b1;
							end_doc_q <= end_doc_base + doc_delta;
							end_off_q <= end_off_base + offset_delta;
						end else begin
							fill_q    <= fill_base;
							end_doc_q <= end_doc_base;
							end_off_q <= end_off_base;
						end
					end else if (do_seek) begin
						query_q <= seek_doc_id;
						if (cursor_q < fill_q) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_WALK: begin
					run_doc_q <= doc_sum;
					run_off_q <= off_sum;
					if (track_ttf_q) begin
						run_ttf_q <= ttf_sum;
					end
					walk_q   <= walk_inc;
					cursor_q <= cursor_nx;
					if (reached) begin
						if (track_bmax_q) begin
							bmax_q <= rd_entry.block_max;
							bpct_q <= rd_entry.block_percent;
						end
						prev_doc_q  <= run_doc_q;
						prev_off_q  <= run_off_q;
						hit_delta_q <= rd_entry.offset_delta;
						status_q    <= slcs_pkg::ST_FOUND;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else if (cursor_nx >= fill_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Buffer ran out: an ended list counts its block once more.
					if (final_q) begin
						walk_q   <= walk_inc;
						status_q <= slcs_pkg::ST_ENDED;
					end else begin
						status_q <= slcs_pkg::ST_LOAD;
					end
					hit_delta_q <= '0;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports.
	assign done                  = done_q;
	assign status                = status_q;
	assign found_doc_id          = run_doc_q;
	assign previous_doc_id       = prev_doc_q;
	assign previous_offset       = prev_off_q;
	assign hit_offset_delta      = hit_delta_q;
	assign total_term_freq       = run_ttf_q;
	assign current_block_max     = bmax_q;
	assign current_block_percent = bpct_q;
	assign skipped_count         = walk_q;
	assign buffer_end_doc        = end_doc_q;
	assign buffer_end_offset     = end_off_q;

	// The cursor never passes the fill, and the fill never passes the depth.
	a_cursor_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= fill_q)
		else $error("cursor beyond buffer fill");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= slcs_pkg::CNT_W'(slcs_pkg::BUFFER_DEPTH))
		else $error("buffer fill beyond depth");

	// A result beat only follows the end of a seek.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy && $past(busy))
		else $error("result beat without a finished seek");

	// An accepted seek always occupies the sequencer.
	a_seek_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_seek |=> busy)
		else $error("seek accepted but sequencer idle");

	// A hit reports the offset delta of the hit entry; a miss never
	// reports a non-zero one.
	a_miss_delta: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != slcs_pkg::ST_FOUND) |-> hit_delta_q == '0)
		else $error("non-zero hit delta on a miss");

endmodule

// ===== sim/skip_list_cursor_seek_top_tb.sv =====
module skip_list_cursor_seek_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_SEEK   = 1'b1;

	// Settling covers the longest seek, which walks a full buffer.
	localparam int SETTLE_CYCLES = 2 * slcs_pkg::BUFFER_DEPTH + 8;
	localparam int QUIET_LIMIT   = 5000;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		logic        req_type;
		logic        first_in_buffer;
		logic        final_buffer;
		logic [31:0] doc_delta;
		logic [31:0] offset_delta;
		logic [31:0] ttf_delta;
		logic [31:0] block_max_freq;
		logic [15:0] block_max_percent;
		logic [31:0] seek_doc_id;
	} cursor_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] found_doc_id;
		logic [31:0] previous_doc_id;
		logic [31:0] previous_offset;
		logic [31:0] hit_offset_delta;
		logic [31:0] total_term_freq;
		logic [31:0] current_block_max;
		logic [15:0] current_block_percent;
		logic [30:0] skipped_count;
		logic [31:0] buffer_end_doc;
		logic [31:0] buffer_end_offset;
	} seek_outcome_t;

	logic        clk                   = 1'b0;
	logic        arst_n                = 1'b0;
	logic        start                 = 1'b0;
	logic        busy;
	logic        req_type              = 1'b0;
	logic        first_in_buffer       = 1'b0;
	logic        final_buffer          = 1'b0;
	logic [31:0] doc_delta             = '0;
	logic [31:0] offset_delta          = '0;
	logic [31:0] ttf_delta             = '0;
	logic [31:0] block_max_freq        = '0;
	logic [15:0] block_max_percent     = '0;
	logic [31:0] seek_doc_id           = '0;
	logic        cfg_valid             = 1'b0;
	logic        cfg_ready;
	logic        cfg_index             = 1'b0;
	logic        cfg_data              = 1'b0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] found_doc_id;
	logic [31:0] previous_doc_id;
	logic [31:0] previous_offset;
	logic [31:0] hit_offset_delta;
	logic [31:0] total_term_freq;
	logic [31:0] current_block_max;
	logic [15:0] current_block_percent;
	logic [30:0] skipped_count;
	logic [31:0] buffer_end_doc;
	logic [31:0] buffer_end_offset;

	// Stimulus waiting for the driver and seek results waiting for the DUT.
	cursor_req_t   req_queue[$];
	seek_outcome_t outcomes_due[$];

	bit beat_taken  = 1'b0;
	int idle_pct    = 31;
	int fault_count = 0;
	int quiet_cycles = 0;
	logic [31:0] plan_doc = '0;

	// Cursor state as the predictor sees it.
	slcs_pkg::entry_t entries [slcs_pkg::BUFFER_DEPTH];
	int          pos_cursor;
	int          fill_level;
	logic        list_done;
	logic [31:0] sum_doc, sum_offset, sum_ttf;
	logic [31:0] prior_doc, prior_offset;
	logic [31:0] held_block_max;
	logic [15:0] held_block_pct;
	logic [30:0] walk_total;
	logic [31:0] end_doc, end_offset;
	logic        cfg_ttf_on, cfg_bmax_on;

	skip_list_cursor_seek_top u_dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Walk counter saturates rather than wrapping.
	function automatic logic [30:0] bump_walk(input logic [30:0] cnt);
		return (cnt == slcs_pkg::WALK_MAX) ? cnt : cnt + 31'd1;
	endfunction

	// Apply one accepted beat to the cursor state; a seek yields an outcome.
	task automatic advance_cursor(input cursor_req_t rq, output bit has_out,
			output seek_outcome_t o);
		logic [31:0] was_doc, was_offset, hit_delta;
		logic [1:0]  st;
		slcs_pkg::entry_t e;
		has_out = 1'b0;
		if (rq.req_type == REQ_APPEND) begin
			if (rq.first_in_buffer) begin
				pos_cursor = 0;
				fill_level = 0;
				end_doc    = sum_doc;
				end_offset = sum_offset;
			end
			list_done = rq.final_buffer;
			if (fill_level < slcs_pkg::BUFFER_DEPTH) begin
				e.doc_delta     = rq.doc_delta;
				e.offset_delta  = rq.offset_delta;
				e.ttf_delta     = rq.ttf_delta;
				e.block_max     = rq.block_max_freq;
				e.block_percent = rq.block_max_percent;
				entries[fill_level] = e;
				end_doc    = end_doc + rq.doc_delta;
				end_offset = end_offset + rq.offset_delta;
				fill_level++;
			end
		end else begin
			hit_delta = '0;
			st = list_done ? slcs_pkg::ST_ENDED : slcs_pkg::ST_LOAD;
			while (pos_cursor < fill_level && st != slcs_pkg::ST_FOUND) begin
				e          = entries[pos_cursor];
				was_doc    = sum_doc;
				was_offset = sum_offset;
				sum_doc    = sum_doc + e.doc_delta;
				sum_offset = sum_offset + e.offset_delta;
				if (cfg_ttf_on)
					sum_ttf = sum_ttf + e.ttf_delta;
				walk_total = bump_walk(walk_total);
				pos_cursor++;
				if (sum_doc >= rq.seek_doc_id) begin
					if (cfg_bmax_on) begin
						held_block_max = e.block_max;
						held_block_pct = e.block_percent;
					end
					prior_doc    = was_doc;
					prior_offset = was_offset;
					hit_delta    = e.offset_delta;
					st           = slcs_pkg::ST_FOUND;
				end
			end
			// An ended list counts the closed block once more on every such seek.
			if (st == slcs_pkg::ST_ENDED)
				walk_total = bump_walk(walk_total);
			o.status                = st;
			o.found_doc_id          = sum_doc;
			o.previous_doc_id       = prior_doc;
			o.previous_offset       = prior_offset;
			o.hit_offset_delta      = hit_delta;
			o.total_term_freq       = sum_ttf;
			o.current_block_max     = held_block_max;
			o.current_block_percent = held_block_pct;
			o.skipped_count         = walk_total;
			o.buffer_end_doc        = end_doc;
			o.buffer_end_offset     = end_offset;
			has_out = 1'b1;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			if (fault_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic push_req(input logic kind, input logic lead, input logic fin,
			input logic [31:0] dd, input logic [31:0] od, input logic [31:0] td,
			input logic [31:0] bm, input logic [15:0] bp, input logic [31:0] q);
		cursor_req_t rq;
		rq.req_type          = kind;
		rq.first_in_buffer   = lead;
		rq.final_buffer      = fin;
		rq.doc_delta         = dd;
		rq.offset_delta      = od;
		rq.ttf_delta         = td;
		rq.block_max_freq    = bm;
		rq.block_max_percent = bp;
		rq.seek_doc_id       = q;
		req_queue.push_back(rq);
	endtask

	// Register beat on the configuration channel, mirrored into the predictor.
	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == slcs_pkg::CFG_TRACK_TTF)
			cfg_ttf_on = val;
		else
			cfg_bmax_on = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold off until the driver is empty and every seek result is back.
	task automatic wait_drained();
		do @(negedge clk);
		while (req_queue.size() != 0 || start || outcomes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed buffers followed by rising queries, some noise.
	task automatic plan_random_traffic(input int budget);
		int          made, n_ent, n_seek, k, roll;
		logic [31:0] span, d, q;
		logic        fin;
		made = 0;
		while (made < budget) begin
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				repeat ($urandom_range(1, 4)) begin
					push_req(1'($urandom), 1'($urandom), 1'($urandom), $urandom,
						$urandom, $urandom, $urandom, 16'($urandom), $urandom);
					made++;
				end
			end else begin
				fin   = ($urandom_range(0, 3) == 0);
				n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
					: $urandom_range(1, 8);
				span  = '0;
				for (k = 0; k < n_ent; k++) begin
					d = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 300);
					span = span + d;
					// roll of one extends the current buffer instead of starting anew
					push_req(REQ_APPEND, (roll != 1) && (k == 0), fin, d, $urandom,
						$urandom, $urandom, 16'($urandom), $urandom);
					made++;
				end
				n_seek = $urandom_range(1, 6);
				for (k = 0; k < n_seek; k++) begin
					q = plan_doc + $urandom_range(0, (span / n_seek) * 2 + 4);
					if ($urandom_range(0, 9) == 0)
						q = $urandom;
					push_req(REQ_SEEK, 1'($urandom), 1'($urandom), $urandom, $urandom,
						$urandom, $urandom, 16'($urandom), q);
					plan_doc = q;
					made++;
				end
			end
		end
	endtask

	// Driver: a new beat is offered once the previous one has been taken.
	always @(negedge clk) begin : driver
		cursor_req_t nx;
		if (!start || beat_taken) begin
			if (req_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nx = req_queue.pop_front();
				req_type          <= nx.req_type;
				first_in_buffer   <= nx.first_in_buffer;
				final_buffer      <= nx.final_buffer;
				doc_delta         <= nx.doc_delta;
				offset_delta      <= nx.offset_delta;
				ttf_delta         <= nx.ttf_delta;
				block_max_freq    <= nx.block_max_freq;
				block_max_percent <= nx.block_max_percent;
				seek_doc_id       <= nx.seek_doc_id;
				start             <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check the strobed result first, then predict the accepted beat.
	always @(posedge clk) begin : monitor
		cursor_req_t   rq;
		seek_outcome_t want;
		bit            has_out;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("result with no seek outstanding, status %0d", status);
			end else begin
				want = outcomes_due.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("found_doc_id", want.found_doc_id, found_doc_id);
				check_field("previous_doc_id", want.previous_doc_id, previous_doc_id);
				check_field("previous_offset", want.previous_offset, previous_offset);
				check_field("hit_offset_delta", want.hit_offset_delta, hit_offset_delta);
				check_field("total_term_freq", want.total_term_freq, total_term_freq);
				check_field("current_block_max", want.current_block_max,
					current_block_max);
				check_field("current_block_percent", 32'(want.current_block_percent),
					32'(current_block_percent));
				check_field("skipped_count", 32'(want.skipped_count),
					32'(skipped_count));
				check_field("buffer_end_doc", want.buffer_end_doc,
					buffer_end_doc);
				check_field("buffer_end_offset", want.buffer_end_offset,
					buffer_end_offset);
			end
		end
		if (arst_n && start && !busy) begin
			rq.req_type          = req_type;
			rq.first_in_buffer   = first_in_buffer;
			rq.final_buffer      = final_buffer;
			rq.doc_delta         = doc_delta;
			rq.offset_delta      = offset_delta;
			rq.ttf_delta         = ttf_delta;
			rq.block_max_freq    = block_max_freq;
			rq.block_max_percent = block_max_percent;
			rq.seek_doc_id       = seek_doc_id;
			advance_cursor(rq, has_out, want);
			if (has_out)
				outcomes_due.push_back(want);
		end
		beat_taken <= arst_n && start && !busy;
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : sequencer
		int ph;
		pos_cursor     = 0;
		fill_level     = 0;
		list_done      = 1'b0;
		sum_doc        = '0;
		sum_offset     = '0;
		sum_ttf        = '0;
		prior_doc      = '0;
		prior_offset   = '0;
		held_block_max = '0;
		held_block_pct = '0;
		walk_total     = '0;
		end_doc        = '0;
		end_offset     = '0;
		cfg_ttf_on     = 1'b0;
		cfg_bmax_on    = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(slcs_pkg::CFG_TRACK_TTF, 1'b1);
		write_reg(slcs_pkg::CFG_TRACK_BMAX, 1'b1);

		// Directed: empty buffer, field extremes, query already reached,
		// exhaustion with and without the final flag, repeated end of list.
		@(posedge clk);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0);
		push_req(REQ_APPEND, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
		push_req(REQ_APPEND, 1'b0, 1'b0, '1, '1, '1, '1, '1, '1);
		push_req(REQ_APPEND, 1'b0, 1'b0, 32'd5, 32'd7, 32'd3, 32'd9, 16'h8000, '0);
		push_req(REQ_SEEK, 1'b1, 1'b1, '1, '1, '1, '1, '1, '0);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '1);
		push_req(REQ_APPEND, 1'b0, 1'b1, 32'hFFFF_FFFB, 32'h1234_5678, 32'h0000_0001,
			32'h8000_0000, 16'h0001, '0);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '1);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '1);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0);
		push_req(REQ_APPEND, 1'b1, 1'b1, 32'd10, 32'd20, 32'd30, 32'd40, 16'hFFFF, '1);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, 32'd100);
		push_req(REQ_APPEND, 1'b1, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4, 16'd5, '0);
		push_req(REQ_APPEND, 1'b0, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4, 16'd5, '0);
		push_req(REQ_SEEK, 1'b0, 1'b0, '0, '0, '0, '0, '0, '1);
		wait_drained();

		// Random phases over every setting; one phase runs without idling.
		for (ph = 0; ph < 4; ph++) begin
			write_reg(slcs_pkg::CFG_TRACK_TTF, ph[0]);
			write_reg(slcs_pkg::CFG_TRACK_BMAX, ph[1]);
			idle_pct = (ph == 2) ? 0 : 31;
			@(posedge clk);
			plan_random_traffic(245);
			wait_drained();
		end

		if (outcomes_due.size() != 0) begin
			fault_count++;
			$display("%0d seek results never arrived", outcomes_due.size());
		end
		if (fault_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
